>>> design/bedw_pkg.sv
// Shared types, constants and helpers for the bitap edit-distance window core.
`default_nettype none

package bedw_pkg;

  localparam int WINDOW_BITS = 64;
  localparam int MAX_LEVELS  = 9;

  localparam int VEC_W   = WINDOW_BITS;
  localparam int IDX_W   = $clog2(WINDOW_BITS);
  localparam int LEN_W   = 7;
  localparam int POS_W   = 6;
  localparam int SYM_W   = 8;
  localparam int LEVEL_W = 4;

  localparam logic [LEVEL_W-1:0] MAX_ERRORS_RESET = 4'd4;

  typedef logic [VEC_W-1:0] vec_t;

  localparam vec_t VEC_ONES = '1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TEXT  = 2'd2
  } op_t;

  // ASCII codes of the four bases in both cases.
  localparam logic [SYM_W-1:0] CH_A_UC = 8'h41;
  localparam logic [SYM_W-1:0] CH_C_UC = 8'h43;
  localparam logic [SYM_W-1:0] CH_G_UC = 8'h47;
  localparam logic [SYM_W-1:0] CH_T_UC = 8'h54;
  localparam logic [SYM_W-1:0] CH_A_LC = 8'h61;
  localparam logic [SYM_W-1:0] CH_C_LC = 8'h63;
  localparam logic [SYM_W-1:0] CH_G_LC = 8'h67;
  localparam logic [SYM_W-1:0] CH_T_LC = 8'h74;

  typedef enum logic [1:0] {
    BASE_A = 2'd0,
    BASE_C = 2'd1,
    BASE_G = 2'd2,
    BASE_T = 2'd3
  } base_t;

  typedef struct packed {
    logic  known;
    base_t code;
  } base_dec_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] length;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] error_level;
    vec_t               match_bits;
    vec_t               subst_bits;
    vec_t               deletion_bits;
    vec_t               insertion_bits;
    logic               hit;
    logic               last;
  } out_item_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic clear;
    logic advance;
  } cell_ctl_t;

  // What one cell hands to the next: the token plus the three vectors that the
  // next level takes from this one.
  typedef struct packed {
    logic valid;
    vec_t subst;
    vec_t del;
    vec_t ins;
  } link_t;

  typedef struct packed {
    vec_t match;
    vec_t subst;
    vec_t del;
    vec_t ins;
    logic hit;
  } cell_res_t;

  function automatic base_dec_t decode_base(input logic [SYM_W-1:0] sym);
    base_dec_t d;
    d.known = 1'b1;
    d.code  = BASE_A;
    case (sym)
      CH_A_UC, CH_A_LC: d.code = BASE_A;
      CH_C_UC, CH_C_LC: d.code = BASE_C;
      CH_G_UC, CH_G_LC: d.code = BASE_G;
      CH_T_UC, CH_T_LC: d.code = BASE_T;
      default:          d.known = 1'b0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> design/bitap_edit_distance_window_core.sv
// Top level of the bitap edit-distance window core: masks, control and result register.
// Start and load transactions take effect as they are accepted. A text base runs through
// one cell per error level, one level per cycle while out_ready is high; in_ready stays
// low until the run passes the highest level. The level 0 result goes through launch_r
// and the result register; later levels follow one per cycle while out_ready is high.
// Synchronous reset: status vectors and base masks all ones, window length 64,
// max_errors 4, no result pending.
`default_nettype none

module bitap_edit_distance_window_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire bedw_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output bedw_pkg::out_item_t               out_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [bedw_pkg::LEVEL_W-1:0]       cfg_data
);
  import bedw_pkg::*;

  logic [LEVEL_W-1:0] max_errors_r;
  logic [LEVEL_W-1:0] top_level;
  logic [LEN_W-1:0]   win_len_r;
  vec_t               hit_mask_r;
  vec_t               base_mask_r [4];
  vec_t               cur_mask_r;
  logic               launch_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  link_t      link [MAX_LEVELS+1];
  cell_res_t  res  [MAX_LEVELS];
  cell_ctl_t  ctl;
  cell_res_t  res_sel;
  logic       busy;
  logic       advance;
  logic       in_fire;
  base_dec_t  dec;
  logic [LEN_W-1:0] len_c;
  logic [LEN_W-1:0] hit_idx;
  logic [LEN_W-1:0] load_idx;
  vec_t       load_bit;
  logic       load_ok;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !busy;
  assign in_fire   = in_valid && in_ready;
  assign dec       = decode_base(in_data.symbol);

  assign top_level = (32'(max_errors_r) >= MAX_LEVELS) ? LEVEL_W'(MAX_LEVELS - 1)
                                                         : max_errors_r;

  always_comb begin
    if (in_data.length == '0) begin
      len_c = LEN_W'(1);
    end else if (32'(in_data.length) > WINDOW_BITS) begin
      len_c = LEN_W'(WINDOW_BITS);
    end else begin
      len_c = in_data.length;
    end
  end

  assign hit_idx = len_c - LEN_W'(1);

  // Pattern position p maps to vector bit (window length - 1 - p).
  assign load_ok  = {1'b0, in_data.position} < win_len_r;
  assign load_idx = win_len_r - LEN_W'(1) - {1'b0, in_data.position};
  assign load_bit = vec_t'(1) << load_idx[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_errors_r <= MAX_ERRORS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_errors_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r  <= LEN_W'(WINDOW_BITS);
      hit_mask_r <= vec_t'(1) << (WINDOW_BITS - 1);
      for (int i = 0; i < 4; i++) begin
        base_mask_r[i] <= VEC_ONES;
      end
    end else if (in_fire) begin
      case (op_t'(in_data.operation))
        OP_START: begin
          win_len_r  <= len_c;
          hit_mask_r <= vec_t'(1) << hit_idx[IDX_W-1:0];
          for (int i = 0; i < 4; i++) begin
            base_mask_r[i] <= VEC_ONES;
          end
        end
        OP_LOAD: begin
          if (load_ok) begin
            for (int i = 0; i < 4; i++) begin
              if (dec.known && (dec.code == base_t'(i))) begin
                base_mask_r[i] <= base_mask_r[i] & ~load_bit;
              end else begin
                base_mask_r[i] <= base_mask_r[i] | load_bit;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (op_t'(in_data.operation) == OP_TEXT) && dec.known) begin
      cur_mask_r <= base_mask_r[dec.code];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r <= 1'b0;
    end else if (in_fire && (op_t'(in_data.operation) == OP_TEXT) && dec.known) begin
      launch_r <= 1'b1;
    end else if (advance) begin
      launch_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
    end else if (in_fire) begin
      lvl_r <= '0;
    end else if (advance && busy) begin
      lvl_r <= lvl_r + LEVEL_W'(1);
    end
  end

  assign ctl.clear   = in_fire && (op_t'(in_data.operation) == OP_START);
  assign ctl.advance = advance;

  // Level 0 sees all ones from below.
  assign link[0].valid = launch_r;
  assign link[0].subst = VEC_ONES;
  assign link[0].del   = VEC_ONES;
  assign link[0].ins   = VEC_ONES;

  for (genvar d = 0; d < MAX_LEVELS; d++) begin : g_cell
    bedw_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .base_mask (cur_mask_r),
      .hit_mask  (hit_mask_r),
      .stop      (32'(top_level) == d),
      .link_in   (link[d]),
      .link_out  (link[d+1]),
      .res       (res[d])
    );
  end

  always_comb begin
    busy    = 1'b0;
    res_sel = '0;
    for (int d = 0; d < MAX_LEVELS; d++) begin
      busy = busy | link[d].valid;
      if (link[d].valid) begin
        res_sel = res_sel | res[d];
      end
    end
    busy = busy | link[MAX_LEVELS].valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && busy) begin
      out_data_r.error_level    <= lvl_r;
      out_data_r.match_bits     <= res_sel.match;
      out_data_r.subst_bits     <= res_sel.subst;
      out_data_r.deletion_bits  <= res_sel.del;
      out_data_r.insertion_bits <= res_sel.ins;
      out_data_r.hit            <= res_sel.hit;
      out_data_r.last           <= (lvl_r == top_level);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  logic [MAX_LEVELS:0] token_vec;
  always_comb begin
    for (int d = 0; d <= MAX_LEVELS; d++) begin
      token_vec[d] = link[d].valid;
    end
  end

  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(token_vec))
    else $error("more than one level active in the chain");

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (lvl_r <= top_level))
    else $error("level counter ran past the highest error level");

  a_launch_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(launch_r) |-> (lvl_r == '0))
    else $error("text transaction launched with a stale level count");
`endif

endmodule

`default_nettype wire

>>> design/bedw_cell.sv
// One error level of the bitap chain: holds its status vector and feeds the next level.
`default_nettype none

module bedw_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire bedw_pkg::cell_ctl_t  ctl,
  input  wire bedw_pkg::vec_t       base_mask,
  input  wire bedw_pkg::vec_t       hit_mask,
  input  wire                       stop,
  input  wire bedw_pkg::link_t      link_in,
  output bedw_pkg::link_t           link_out,
  output bedw_pkg::cell_res_t       res
);
  import bedw_pkg::*;

  vec_t vec_r;
  vec_t match_v;
  vec_t new_v;
  logic valid_r;
  vec_t subst_r;
  vec_t del_r;
  vec_t ins_r;

  assign match_v = (vec_r << 1) | base_mask;
  assign new_v   = match_v & link_in.subst & link_in.del & link_in.ins;

  assign res.match = match_v;
  assign res.subst = link_in.subst;
  assign res.del   = link_in.del;
  assign res.ins   = link_in.ins;
  assign res.hit   = ~|(new_v & hit_mask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r <= VEC_ONES;
    end else if (ctl.clear) begin
      vec_r <= VEC_ONES;
    end else if (ctl.advance && link_in.valid) begin
      vec_r <= new_v;
    end
  end

  // The token moves on unless this cell holds the highest level of the run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.advance) begin
      valid_r <= link_in.valid && !stop;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && link_in.valid) begin
      subst_r <= vec_r << 1;
      del_r   <= vec_r;
      ins_r   <= new_v << 1;
    end
  end

  assign link_out.valid = valid_r;
  assign link_out.subst = subst_r;
  assign link_out.del   = del_r;
  assign link_out.ins   = ins_r;

endmodule

`default_nettype wire
